// File: rtl/core/clg_pkg.sv
// Shared constants, codes and controller/datapath interface types for the lattice gas step.
package clg_pkg;

  localparam int unsigned MAX_SITES = 1024;
  localparam int unsigned SITE_W    = $clog2(MAX_SITES);
  localparam int unsigned CNT_W     = SITE_W + 1;
  localparam int unsigned PAIR_W    = 12;
  localparam int unsigned LIM_W     = 16;
  localparam int unsigned THR_W     = 4;
  localparam int unsigned CFG_W     = 16;

  localparam logic [CNT_W-1:0]  LEN_MIN   = CNT_W'(4);
  localparam logic [CNT_W-1:0]  LEN_MAX   = CNT_W'(MAX_SITES);
  localparam logic [CNT_W-1:0]  PART_MAX  = {CNT_W{1'b1}};
  localparam logic [PAIR_W-1:0] PAIR_MAX  = {PAIR_W{1'b1}};
  localparam logic [LIM_W-1:0]  LIM_MAX   = {LIM_W{1'b1}};

  localparam logic [1:0] CMD_GEN    = 2'd0;
  localparam logic [1:0] CMD_MOVE   = 2'd1;
  localparam logic [1:0] CMD_INSDEL = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_NOCHG  = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  localparam logic [1:0] CFG_LEN   = 2'd0;
  localparam logic [1:0] CFG_TRY   = 2'd1;
  localparam logic [1:0] CFG_MOVES = 2'd2;
  localparam logic [1:0] CFG_THR   = 2'd3;

  localparam logic [2:0] K_REJ  = 3'd0;
  localparam logic [2:0] K_GEN  = 3'd1;
  localparam logic [2:0] K_MOVE = 3'd2;
  localparam logic [2:0] K_INS  = 3'd3;
  localparam logic [2:0] K_DEL  = 3'd4;

  localparam logic [3:0] MOD_LAST = 4'(SITE_W - 1);
  localparam logic [3:0] ORD_LAST = 4'd5;

  typedef struct packed {
    logic       cap;
    logic       dec;
    logic       mod_step;
    logic       mod_first;
    logic [3:0] step;
    logic       ord_en;
    logic       eval;
    logic       wr1;
    logic       wr2;
    logic       fin;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] kind_q;
    logic       ok;
  } stat_t;

endpackage

// File: rtl/core/clg_ctrl.sv
// Sequencer that steps one request through decode, modulo, reads, writes and result.
module clg_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  clg_pkg::stat_t stat_i,
  output clg_pkg::cmd_t  cmd_o
);
  import clg_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_ORD  = 3'd3;
  localparam logic [2:0] S_EVAL = 3'd4;
  localparam logic [2:0] S_WR1  = 3'd5;
  localparam logic [2:0] S_WR2  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.step = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.dec = 1'b1;
        cnt_d     = '0;
        case (stat_i.kind)
          K_MOVE, K_INS: state_d = S_MOD;
          K_DEL:         state_d = S_ORD;
          default:       state_d = S_FIN;
        endcase
      end
      S_MOD: begin
        cmd_o.mod_step  = 1'b1;
        cmd_o.mod_first = (cnt_q == '0);
        if (cnt_q == MOD_LAST) begin
          cnt_d   = '0;
          state_d = S_ORD;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_ORD: begin
        cmd_o.ord_en = 1'b1;
        if (cnt_q == ORD_LAST) begin
          state_d = S_EVAL;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = stat_i.ok ? S_WR1 : S_FIN;
      end
      S_WR1: begin
        cmd_o.wr1 = 1'b1;
        state_d   = (stat_i.kind_q == K_MOVE) ? S_WR2 : S_FIN;
      end
      S_WR2: begin
        cmd_o.wr2 = 1'b1;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.fin) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/clg_datapath.sv
// Lattice and empty-list memories, counters, modulo unit and result register.
module clg_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  clg_pkg::cmd_t                  cmd_i,
  output clg_pkg::stat_t                 stat_o,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_index_i,
  input  logic [clg_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic [1:0]                     cmd_field_i,
  input  logic [clg_pkg::SITE_W-1:0]     pick_index_i,
  input  logic [clg_pkg::SITE_W-1:0]     site_index_i,
  input  logic                           direction_i,
  input  logic                           coin_i,
  input  logic [3:0]                     random_digit_i,
  output logic [1:0]                     status_o,
  output logic [clg_pkg::SITE_W-1:0]     changed_site_o,
  output logic [clg_pkg::CNT_W-1:0]      occupied_count_o,
  output logic [clg_pkg::PAIR_W-1:0]     pair_count_o,
  output logic [clg_pkg::CNT_W-1:0]      empty_count_o,
  output logic [clg_pkg::LIM_W-1:0]      moves_made_o,
  output logic                           run_done_o
);
  import clg_pkg::*;

  logic                occ_mem [MAX_SITES];
  logic [SITE_W-1:0]   lst_mem [MAX_SITES];

  logic [CNT_W-1:0]  cfg_len_q;
  logic [LIM_W-1:0]  try_lim_q, mv_lim_q;
  logic [THR_W-1:0]  thr_q;

  logic [CNT_W-1:0]  et_q, p_q, gp_q;
  logic [PAIR_W-1:0] q_q;
  logic [LIM_W-1:0]  try_q, mv_q;
  logic              last_q, occ0_q;

  logic [1:0]        op_q;
  logic [SITE_W-1:0] pick_q, site_q;
  logic              dir_q, coin_q;
  logic [3:0]        digit_q;

  logic [2:0]        kind_q;
  logic [1:0]        st_q;
  logic [SITE_W-1:0] chg_q;
  logic [CNT_W-1:0]  rem_q;
  logic [SITE_W-1:0] lrd_q;
  logic              ord_q;
  logic              o_c_q, o_l1_q, o_r1_q, o_l2_q, o_r2_q;

  logic [CNT_W-1:0]  len;
  logic              run_done, del_sel, ok, left;
  logic [2:0]        kind;
  logic [SITE_W-1:0] gi;
  logic              gv;
  logic [PAIR_W-1:0] q_a, q_b;
  logic [CNT_W-1:0]  l1, r1, l2, r2, src;
  logic [SITE_W-1:0] idx;
  logic [CNT_W-1:0]  mod_in, mod_t, mod_n;
  logic              mod_bit;
  logic [SITE_W-1:0] ora;
  logic              owe, owd;
  logic [SITE_W-1:0] owa;
  logic              lwe;
  logic [SITE_W-1:0] lwa, lwd, lra;
  logic              lre;
  logic [PAIR_W:0]   q_ins;
  logic [PAIR_W-1:0] q_mv1;
  logic [CNT_W-1:0]  p_dec;

  always_comb begin
    len = cfg_len_q;
    if (cfg_len_q < LEN_MIN) len = LEN_MIN;
    if (cfg_len_q > LEN_MAX) len = LEN_MAX;
  end

  assign run_done = (try_q >= try_lim_q) || (mv_q >= mv_lim_q);

  always_comb begin
    if (p_q <= (len >> 1)) del_sel = 1'b0;
    else if (p_q >= len)   del_sel = 1'b1;
    else                   del_sel = coin_q;
  end

  always_comb begin
    kind = K_REJ;
    case (op_q)
      CMD_GEN: begin
        if (gp_q < len) kind = K_GEN;
      end
      CMD_MOVE: begin
        if (gp_q >= len && !(p_q >= len || et_q == '0 || run_done ||
            {1'b0, pick_q} >= et_q)) kind = K_MOVE;
      end
      CMD_INSDEL: begin
        if (gp_q >= len) begin
          if (!del_sel) begin
            if ({1'b0, pick_q} < et_q) kind = K_INS;
          end else if ({1'b0, site_q} < len) begin
            kind = K_DEL;
          end
        end
      end
      default: kind = K_REJ;
    endcase
  end

  assign gi  = gp_q[SITE_W-1:0];
  assign gv  = !gi[0] || (digit_q < thr_q);
  assign q_a = (gi != '0 && gv && last_q && q_q != PAIR_MAX) ? q_q + 1'b1 : q_q;
  assign q_b = ((gp_q + 1'b1) == len && gv && occ0_q && q_a != PAIR_MAX) ? q_a + 1'b1 : q_a;

  assign idx = rem_q[SITE_W-1:0];
  assign l1  = (rem_q == '0) ? len - 1'b1 : rem_q - 1'b1;
  assign r1  = (rem_q == len - 1'b1) ? '0 : rem_q + 1'b1;
  assign l2  = (rem_q < CNT_W'(2)) ? rem_q + len - CNT_W'(2) : rem_q - CNT_W'(2);
  assign r2  = (rem_q + CNT_W'(2) >= len) ? rem_q + CNT_W'(2) - len : rem_q + CNT_W'(2);
  assign left = !dir_q && o_l2_q;
  assign src  = left ? l1 : r1;

  assign mod_bit = lrd_q[MOD_LAST - cmd_i.step];
  assign mod_in  = cmd_i.mod_first ? '0 : rem_q;
  assign mod_t   = {mod_in[SITE_W-1:0], mod_bit};
  assign mod_n   = (mod_t >= len) ? mod_t - len : mod_t;

  always_comb begin
    case (kind_q)
      K_MOVE:  ok = !o_c_q && (left ? o_l1_q : (o_r2_q && o_r1_q));
      K_INS:   ok = !o_c_q;
      K_DEL:   ok = o_l1_q && o_c_q && o_r1_q && (et_q < LEN_MAX);
      default: ok = 1'b0;
    endcase
  end

  assign stat_o.kind   = kind;
  assign stat_o.kind_q = kind_q;
  assign stat_o.ok     = ok;

  always_comb begin
    case (cmd_i.step)
      4'd0:    ora = idx;
      4'd1:    ora = l1[SITE_W-1:0];
      4'd2:    ora = r1[SITE_W-1:0];
      4'd3:    ora = l2[SITE_W-1:0];
      4'd4:    ora = r2[SITE_W-1:0];
      default: ora = idx;
    endcase
  end

  always_comb begin
    owe = 1'b0;
    owa = idx;
    owd = 1'b0;
    lwe = 1'b0;
    lwa = pick_q;
    lwd = idx;
    if (cmd_i.dec && kind == K_GEN) begin
      owe = 1'b1;
      owa = gi;
      owd = gv;
      lwe = !gv && (et_q < LEN_MAX);
      lwa = et_q[SITE_W-1:0];
      lwd = gi;
    end else if (cmd_i.wr1) begin
      owe = 1'b1;
      lwe = 1'b1;
      case (kind_q)
        K_MOVE: begin
          owa = src[SITE_W-1:0];
          owd = 1'b0;
          lwd = src[SITE_W-1:0];
        end
        K_INS: begin
          owd = 1'b1;
          lwd = lrd_q;
        end
        default: begin
          owd = 1'b0;
          lwa = et_q[SITE_W-1:0];
        end
      endcase
    end else if (cmd_i.wr2) begin
      owe = 1'b1;
      owd = 1'b1;
    end
  end

  assign lre = cmd_i.dec || cmd_i.eval;
  assign lra = cmd_i.eval ? SITE_W'(et_q - 1'b1) : pick_q;

  always_ff @(posedge clk_i) begin
    if (owe) occ_mem[owa] <= owd;
    if (cmd_i.ord_en) ord_q <= occ_mem[ora];
  end

  always_ff @(posedge clk_i) begin
    if (lwe) lst_mem[lwa] <= lwd;
    if (lre) lrd_q <= lst_mem[lra];
  end

  assign q_ins = {1'b0, q_q} + (PAIR_W+1)'(o_l1_q) + (PAIR_W+1)'(o_r1_q);
  assign q_mv1 = (q_q > PAIR_W'(1)) ? q_q - 1'b1 : '0;
  assign p_dec = (p_q != '0) ? p_q - 1'b1 : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q    <= cmd_field_i;
      pick_q  <= pick_index_i;
      site_q  <= site_index_i;
      dir_q   <= direction_i;
      coin_q  <= coin_i;
      digit_q <= random_digit_i;
    end
    if (cmd_i.dec) begin
      kind_q <= kind;
      rem_q  <= {1'b0, site_q};
      st_q   <= (kind == K_GEN) ? ST_DONE : ST_REJECT;
      chg_q  <= (kind == K_GEN) ? gi : '0;
    end
    if (cmd_i.mod_step) rem_q <= mod_n;
    if (cmd_i.ord_en) begin
      case (cmd_i.step)
        4'd1:    o_c_q  <= ord_q;
        4'd2:    o_l1_q <= ord_q;
        4'd3:    o_r1_q <= ord_q;
        4'd4:    o_l2_q <= ord_q;
        4'd5:    o_r2_q <= ord_q;
        default: o_c_q  <= o_c_q;
      endcase
    end
    if (cmd_i.eval) begin
      st_q  <= ok ? ST_DONE : ST_NOCHG;
      chg_q <= ok ? idx : '0;
    end
    if (cmd_i.fin) begin
      status_o         <= st_q;
      changed_site_o   <= chg_q;
      occupied_count_o <= p_q;
      pair_count_o     <= q_q;
      empty_count_o    <= et_q;
      moves_made_o     <= mv_q;
      run_done_o       <= run_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= CNT_W'(16);
      try_lim_q <= LIM_W'(50);
      mv_lim_q  <= LIM_W'(5);
      thr_q     <= THR_W'(2);
      et_q      <= '0;
      p_q       <= '0;
      q_q       <= '0;
      gp_q      <= '0;
      try_q     <= '0;
      mv_q      <= '0;
      last_q    <= 1'b1;
      occ0_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_LEN: cfg_len_q <= cfg_data_i[CNT_W-1:0];
          CFG_TRY: begin
            try_lim_q <= cfg_data_i[LIM_W-1:0];
            try_q     <= '0;
            mv_q      <= '0;
          end
          CFG_MOVES: begin
            mv_lim_q <= cfg_data_i[LIM_W-1:0];
            try_q    <= '0;
            mv_q     <= '0;
          end
          default: thr_q <= cfg_data_i[THR_W-1:0];
        endcase
      end
      if (owe && owa == '0) occ0_q <= owd;
      if (cmd_i.dec && kind == K_GEN) begin
        q_q    <= q_b;
        gp_q   <= gp_q + 1'b1;
        last_q <= gv;
        if (gv) begin
          if (p_q != PART_MAX) p_q <= p_q + 1'b1;
        end else if (et_q < LEN_MAX) begin
          et_q <= et_q + 1'b1;
        end
      end
      if (cmd_i.eval && kind_q == K_MOVE && !ok && try_q != LIM_MAX) begin
        try_q <= try_q + 1'b1;
      end
      if (cmd_i.wr1) begin
        case (kind_q)
          K_MOVE: begin
            q_q   <= q_mv1 + PAIR_W'(left ? o_r1_q : o_l1_q);
            p_q   <= (p_dec != PART_MAX) ? p_dec + 1'b1 : p_dec;
            try_q <= '0;
            if (mv_q != LIM_MAX) mv_q <= mv_q + 1'b1;
          end
          K_INS: begin
            q_q  <= (q_ins > {1'b0, PAIR_MAX}) ? PAIR_MAX : q_ins[PAIR_W-1:0];
            if (p_q != PART_MAX) p_q <= p_q + 1'b1;
            et_q <= et_q - 1'b1;
          end
          default: begin
            q_q  <= (q_q > PAIR_W'(2)) ? q_q - PAIR_W'(2) : '0;
            p_q  <= p_dec;
            et_q <= et_q + 1'b1;
          end
        endcase
      end
    end
  end

endmodule

// File: rtl/core/conserved_lattice_gas_step.sv
// Top level of the one-dimensional conserved lattice gas step engine.
// One request is in flight at a time. A generate or a rejected request goes from decode
// straight to the result. A delete reads the lattice, then evaluates, writes and finishes;
// an insert or a move first runs a bit-serial modulo of the empty-list entry by the
// lattice length, and a move writes twice. When nothing changes, the writes are skipped.
// Every move, insert or delete reads the site and its four neighbors one lattice-memory
// bit per cycle. A new request is taken as soon as the previous one has reached the output
// register, even while that result still waits to be taken; a waiting result holds only
// the final step of the next request.
module conserved_lattice_gas_step (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [clg_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 cmd_i,
  input  logic [clg_pkg::SITE_W-1:0] pick_index_i,
  input  logic [clg_pkg::SITE_W-1:0] site_index_i,
  input  logic                       direction_i,
  input  logic                       coin_i,
  input  logic [3:0]                 random_digit_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic [clg_pkg::SITE_W-1:0] changed_site_o,
  output logic [clg_pkg::CNT_W-1:0]  occupied_count_o,
  output logic [clg_pkg::PAIR_W-1:0] pair_count_o,
  output logic [clg_pkg::CNT_W-1:0]  empty_count_o,
  output logic [clg_pkg::LIM_W-1:0]  moves_made_o,
  output logic                       run_done_o
);
  import clg_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  clg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  clg_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_field_i      (cmd_i),
    .pick_index_i     (pick_index_i),
    .site_index_i     (site_index_i),
    .direction_i      (direction_i),
    .coin_i           (coin_i),
    .random_digit_i   (random_digit_i),
    .status_o         (status_o),
    .changed_site_o   (changed_site_o),
    .occupied_count_o (occupied_count_o),
    .pair_count_o     (pair_count_o),
    .empty_count_o    (empty_count_o),
    .moves_made_o     (moves_made_o),
    .run_done_o       (run_done_o)
  );

endmodule

// File: rtl/core/clg_checker.sv
// Port-level checker for the lattice gas step, bound to the top level.
module clg_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [1:0]                 status_o,
  input logic [clg_pkg::SITE_W-1:0] changed_site_o
);
  import clg_pkg::*;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_DONE || status_o == ST_NOCHG || status_o == ST_REJECT))
    else $error("undefined status code");

  a_site_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_DONE |-> changed_site_o == '0)
    else $error("changed site set without a change");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped before it was taken");

endmodule

bind conserved_lattice_gas_step clg_checker u_clg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .changed_site_o (changed_site_o)
);
